FILE: src/ebc_pkg.sv
// Package for the escaped-byte CRC-32 block: beat types, escape codes
// and the byte-wide CRC and bit-reversal functions. No dependencies.
package ebc_pkg;

  localparam int unsigned CrcWidth  = 32;
  localparam int unsigned ByteWidth = 8;

  localparam logic [CrcWidth-1:0]  PolyReset = 32'h04C1_1DB7;
  localparam logic [CrcWidth-1:0]  InitReset = 32'h0000_0000;
  localparam logic [CrcWidth-1:0]  XorReset  = 32'h0000_0000;
  localparam logic [ByteWidth-1:0] EscChar   = 8'h25;

  // Configuration register indexes.
  localparam logic [1:0] RegPolynomial = 2'd0;
  localparam logic [1:0] RegInitValue  = 2'd1;
  localparam logic [1:0] RegXorOut     = 2'd2;

  // Escape phases. The unused code behaves like PhaseAfterFirst.
  localparam logic [1:0] PhaseNone       = 2'd0;
  localparam logic [1:0] PhaseAfterPct   = 2'd1;
  localparam logic [1:0] PhaseAfterFirst = 2'd2;

  typedef struct packed {
    logic [ByteWidth-1:0] data_byte;
    logic                 last_byte;
  } in_beat_t;

  // Eight CRC bit steps, data taken least significant bit first.
  function automatic logic [CrcWidth-1:0] crc_byte(
    input logic [CrcWidth-1:0]  crc,
    input logic [CrcWidth-1:0]  poly,
    input logic [ByteWidth-1:0] b
  );
    logic [CrcWidth-1:0] c;
    logic                fb;
    c = crc;
    for (int j = 0; j < ByteWidth; j++) begin
      fb = c[CrcWidth-1] ^ b[j];
      c  = {c[CrcWidth-2:0], 1'b0} ^ (fb ? poly : '0);
    end
    return c;
  endfunction

  function automatic logic [CrcWidth-1:0] reverse32(input logic [CrcWidth-1:0] v);
    logic [CrcWidth-1:0] r;
    for (int i = 0; i < CrcWidth; i++) begin
      r[CrcWidth-1-i] = v[i];
    end
    return r;
  endfunction

endpackage

FILE: src/ebc_in_reg.sv
// Input register of the escaped-byte CRC-32 block: holds one accepted
// character beat until the CRC core takes it. Depends on ebc_pkg.
module ebc_in_reg (
  input  logic              clk,
  input  logic              rst,
  input  logic              s_tvalid,
  output logic              s_tready,
  input  logic [7:0]        s_tdata,   // data_byte[7:0]
  input  logic              s_tlast,   // last_byte
  output logic              beat_valid,
  output ebc_pkg::in_beat_t beat,
  input  logic              beat_take
);

  logic              full;
  ebc_pkg::in_beat_t hold;

  // The slot frees up in the same cycle in which the core takes it.
  assign s_tready   = !full || beat_take;
  assign beat_valid = full;
  assign beat       = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      full <= 1'b0;
    end else if (s_tvalid && s_tready) begin
      full <= 1'b1;
    end else if (beat_take) begin
      full <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      hold.data_byte <= s_tdata;
      hold.last_byte <= s_tlast;
    end
  end

endmodule

FILE: src/ebc_crc_core.sv
// CRC core of the escaped-byte CRC-32 block: escape decoding, CRC state
// update and the result register. Depends on ebc_pkg.
module ebc_crc_core (
  input  logic              clk,
  input  logic              rst,
  input  logic [31:0]       polynomial,
  input  logic [31:0]       init_value,
  input  logic [31:0]       xor_out,
  input  logic              beat_valid,
  input  ebc_pkg::in_beat_t beat,
  output logic              beat_take,
  output logic              m_tvalid,
  input  logic              m_tready,
  output logic [31:0]       m_tdata,   // crc_value[31:0]
  output logic              m_tuser    // failed
);

  logic [31:0] crc;
  logic [31:0] crc_next;
  logic [1:0]  phase;
  logic [1:0]  phase_next;
  logic [3:0]  high_nibble;
  logic [3:0]  high_nibble_next;
  logic        feed;
  logic [7:0]  feed_value;
  logic [31:0] crc_fed;
  logic        fail_now;
  logic [31:0] result_now;
  logic        out_free;

  assign out_free = !m_tvalid || m_tready;
  // A beat that yields no result never waits on the output side.
  assign beat_take = beat_valid && (!beat.last_byte || out_free);

  always_comb begin
    feed             = 1'b0;
    feed_value       = beat.data_byte;
    phase_next       = phase;
    high_nibble_next = high_nibble;
    case (phase)
      ebc_pkg::PhaseNone: begin
        if (beat.data_byte == ebc_pkg::EscChar) begin
          phase_next = ebc_pkg::PhaseAfterPct;
        end else begin
          feed = 1'b1;
        end
      end
      ebc_pkg::PhaseAfterPct: begin
        high_nibble_next = beat.data_byte[3:0];
        phase_next       = ebc_pkg::PhaseAfterFirst;
      end
      default: begin
        feed             = 1'b1;
        feed_value       = {high_nibble, beat.data_byte[3:0]};
        phase_next       = ebc_pkg::PhaseNone;
        high_nibble_next = '0;
      end
    endcase
    crc_fed    = feed ? ebc_pkg::crc_byte(crc, polynomial, feed_value) : crc;
    fail_now   = (phase_next != ebc_pkg::PhaseNone);
    result_now = fail_now ? '0 : (ebc_pkg::reverse32(crc_fed) ^ xor_out);
    crc_next   = crc_fed;
    if (beat.last_byte) begin
      crc_next         = init_value;
      phase_next       = ebc_pkg::PhaseNone;
      high_nibble_next = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      crc         <= ebc_pkg::InitReset;
      phase       <= ebc_pkg::PhaseNone;
      high_nibble <= '0;
    end else if (beat_take) begin
      crc         <= crc_next;
      phase       <= phase_next;
      high_nibble <= high_nibble_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (beat_take && beat.last_byte) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (beat_take && beat.last_byte) begin
      m_tdata <= result_now;
      m_tuser <= fail_now;
    end
  end

endmodule

FILE: src/escaped_byte_crc32.sv
// Top level of the escaped-byte CRC-32 block: configuration registers and
// the input register and CRC core. Depends on ebc_pkg, ebc_in_reg and
// ebc_crc_core.
//
// Usage:
//   Characters of a message arrive on the s_ stream, one per beat, with
//   s_tlast on the final one. A '%' starts an escape whose next two
//   characters give one byte from their low nibbles. For each message one
//   result beat leaves on the m_ stream: m_tdata is the bit-reversed CRC
//   register XOR xor_out, m_tuser is set (and m_tdata is zero) when the
//   message ended inside an escape. The CRC register then reloads
//   init_value.
//   A character is taken every cycle while no final character waits on a
//   stalled receiver. The input register is loaded on acceptance; for the
//   final character the result register is loaded from it in turn, with
//   the eight CRC bit steps unrolled in between, and m_tvalid rises.
//   While the result register is held by a stalled receiver, characters
//   that do not end a message keep flowing; a final character waits in
//   the input register, after which s_tready drops.
//   The cfg_ channel writes polynomial (index 0), init_value (index 1) and
//   xor_out (index 2); other indexes are ignored. It is always ready.
//   Reset restores polynomial 0x04C11DB7, init_value 0, xor_out 0 and
//   clears both registers and the escape state.
module escaped_byte_crc32 (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte[7:0]
  input  logic        s_tlast,    // last_byte
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [31:0] m_tdata,    // crc_value[31:0]
  output logic [0:0]  m_tuser,    // failed
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data
);

  logic [31:0]       polynomial;
  logic [31:0]       init_value;
  logic [31:0]       xor_out;
  logic              beat_valid;
  logic              beat_take;
  ebc_pkg::in_beat_t beat;

  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      polynomial <= ebc_pkg::PolyReset;
      init_value <= ebc_pkg::InitReset;
      xor_out    <= ebc_pkg::XorReset;
    end else if (cfg_valid && cfg_ready) begin
      unique case (cfg_index)
        ebc_pkg::RegPolynomial: polynomial <= cfg_data;
        ebc_pkg::RegInitValue:  init_value <= cfg_data;
        ebc_pkg::RegXorOut:     xor_out    <= cfg_data;
        default: ;
      endcase
    end
  end

  ebc_in_reg u_in_reg (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tlast    (s_tlast),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take)
  );

  ebc_crc_core u_crc_core (
    .clk        (clk),
    .rst        (rst),
    .polynomial (polynomial),
    .init_value (init_value),
    .xor_out    (xor_out),
    .beat_valid (beat_valid),
    .beat       (beat),
    .beat_take  (beat_take),
    .m_tvalid   (m_tvalid),
    .m_tready   (m_tready),
    .m_tdata    (m_tdata),
    .m_tuser    (m_tuser[0])
  );

endmodule

FILE: tb/ebc_checker.sv
// Checker for the escaped-byte CRC-32 block: watches the character, result
// and register write channels, predicts each message's result and compares.
// Depends on ebc_pkg for the register indexes, escape phases and reset values.
module ebc_checker (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  input  logic        s_tready,
  input  logic [7:0]  s_tdata,    // data_byte[7:0]
  input  logic        s_tlast,    // last_byte
  input  logic        m_tvalid,
  input  logic        m_tready,
  input  logic [31:0] m_tdata,    // crc_value[31:0]
  input  logic [0:0]  m_tuser,    // failed
  input  logic        cfg_valid,
  input  logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  output int          errors,
  output int          pending
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [31:0] crc_value;
    logic        failed;
  } crc_result_t;

  crc_result_t crc_expect_q[$];

  logic [31:0] poly_q;
  logic [31:0] init_q;
  logic [31:0] xorout_q;
  logic [31:0] crc_q;
  logic [1:0]  esc_phase;
  logic [3:0]  hi_nib;

  // One data byte into the shift register, least significant bit first.
  function automatic logic [31:0] crc_shift_byte(input logic [31:0] crc,
                                                 input logic [31:0] poly,
                                                 input logic [7:0]  d);
    logic [31:0] c;
    logic        msb;
    c = crc;
    for (int i = 0; i < 8; i++) begin
      msb = c[31] ^ d[i];
      c = c << 1;
      if (msb) begin
        c = c ^ poly;
      end
    end
    return c;
  endfunction

  function automatic logic [31:0] bit_reverse32(input logic [31:0] v);
    logic [31:0] r;
    for (int i = 0; i < 32; i++) begin
      r[i] = v[31-i];
    end
    return r;
  endfunction

  task automatic report_mismatch(input string what);
    $display("ERROR at %0t ns: %s", $time, what);
    errors++;
  endtask

  task automatic take_char(input logic [7:0] ch, input logic last);
    crc_result_t res;
    case (esc_phase)
      ebc_pkg::PhaseNone: begin
        if (ch == ebc_pkg::EscChar) begin
          esc_phase = ebc_pkg::PhaseAfterPct;
        end else begin
          crc_q = crc_shift_byte(crc_q, poly_q, ch);
        end
      end
      ebc_pkg::PhaseAfterPct: begin
        hi_nib = ch[3:0];
        esc_phase = ebc_pkg::PhaseAfterFirst;
      end
      default: begin
        crc_q = crc_shift_byte(crc_q, poly_q, {hi_nib, ch[3:0]});
        esc_phase = ebc_pkg::PhaseNone;
        hi_nib = '0;
      end
    endcase
    if (last) begin
      // A message that stops inside an escape reports failure and no CRC.
      if (esc_phase != ebc_pkg::PhaseNone) begin
        res.crc_value = '0;
        res.failed = 1'b1;
      end else begin
        res.crc_value = bit_reverse32(crc_q) ^ xorout_q;
        res.failed = 1'b0;
      end
      crc_expect_q = {crc_expect_q, res};
      crc_q = init_q;
      esc_phase = ebc_pkg::PhaseNone;
      hi_nib = '0;
    end
  endtask

  task automatic check_result(input logic [31:0] crc, input logic failed);
    crc_result_t exp;
    if (crc_expect_q.size() == 0) begin
      report_mismatch($sformatf("result beat crc=%08h failed=%0b with no message pending",
                                crc, failed));
    end else begin
      exp = crc_expect_q.pop_front();
      if (crc !== exp.crc_value) begin
        report_mismatch($sformatf("crc_value %08h, expected %08h", crc, exp.crc_value));
      end
      if (failed !== exp.failed) begin
        report_mismatch($sformatf("failed %0b, expected %0b", failed, exp.failed));
      end
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      poly_q = ebc_pkg::PolyReset;
      init_q = ebc_pkg::InitReset;
      xorout_q = ebc_pkg::XorReset;
      crc_q = ebc_pkg::InitReset;
      esc_phase = ebc_pkg::PhaseNone;
      hi_nib = '0;
      crc_expect_q.delete();
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          ebc_pkg::RegPolynomial: poly_q = cfg_data;
          ebc_pkg::RegInitValue:  init_q = cfg_data;
          ebc_pkg::RegXorOut:     xorout_q = cfg_data;
          default: ;
        endcase
      end
      if (s_tvalid && s_tready) begin
        take_char(s_tdata, s_tlast);
      end
      if (m_tvalid && m_tready) begin
        check_result(m_tdata, m_tuser[0]);
      end
    end
    pending = crc_expect_q.size();
  end

endmodule

FILE: tb/testbench.sv
// Top of the escaped-byte CRC-32 testbench: clock, reset, character and
// register write stimulus, receiver back-pressure and the verdict.
// Depends on ebc_pkg, escaped_byte_crc32 and ebc_checker.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [1:0] RegUnused = 2'd3;
  localparam int unsigned HoldCycles = 80;
  localparam int unsigned CharsPerPhase = 200;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [7:0]  s_tdata;
  logic        s_tlast;
  logic        m_tvalid;
  logic        m_tready;
  logic [31:0] m_tdata;
  logic [0:0]  m_tuser;
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [31:0] cfg_data;
  int          errors;
  int          pending;

  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  int unsigned chars_sent;

  escaped_byte_crc32 u_dut (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  ebc_checker u_checker (
    .clk       (clk),
    .rst       (rst),
    .s_tvalid  (s_tvalid),
    .s_tready  (s_tready),
    .s_tdata   (s_tdata),
    .s_tlast   (s_tlast),
    .m_tvalid  (m_tvalid),
    .m_tready  (m_tready),
    .m_tdata   (m_tdata),
    .m_tuser   (m_tuser),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .errors    (errors),
    .pending   (pending)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  initial begin
    #10ms;
    $display("*** FAILED ***");
    $finish;
  end

  // Receiver: random back-pressure, or one long hold-off when requested.
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        hold_req = 1'b0;
        m_tready = 1'b0;
        repeat (HoldCycles - 1) @(negedge clk);
      end else begin
        m_tready = ($urandom_range(99) >= snk_idle_pct);
      end
    end
  end

  // Called at a falling edge; returns at the falling edge after the beat.
  // Valid stays high into the next call unless the sender idles.
  task automatic send_char(input logic [7:0] ch, input logic last);
    while ($urandom_range(99) < src_idle_pct) begin
      s_tvalid = 1'b0;
      s_tdata = 8'($urandom);
      s_tlast = 1'($urandom);
      @(negedge clk);
    end
    s_tvalid = 1'b1;
    s_tdata = ch;
    s_tlast = last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    @(negedge clk);
    chars_sent++;
  endtask

  task automatic send_message(input logic [7:0] msg[$]);
    foreach (msg[i]) begin
      send_char(msg[i], i == msg.size() - 1);
    end
  endtask

  function automatic logic [7:0] escape_char();
    case ($urandom_range(3))
      0: return ebc_pkg::EscChar;
      1: return 8'h30 + 8'($urandom_range(9));
      2: return 8'h41 + 8'($urandom_range(5));
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly well-formed messages with explicit escapes; some carry raw noise
  // and some are cut off inside an escape.
  task automatic send_random_message();
    logic [7:0]  msg[$];
    logic [7:0]  b;
    int unsigned len;
    int unsigned kind;
    len = ($urandom_range(15) == 0) ? $urandom_range(40, 1) : $urandom_range(8, 1);
    kind = $urandom_range(99);
    while (msg.size() < len) begin
      if (kind < 10) begin
        msg = {msg, 8'($urandom)};
      end else if ($urandom_range(3) == 0) begin
        msg = {msg, ebc_pkg::EscChar};
        msg = {msg, escape_char()};
        msg = {msg, escape_char()};
      end else begin
        b = 8'($urandom);
        if (b == ebc_pkg::EscChar) begin
          b = 8'h26;
        end
        msg = {msg, b};
      end
    end
    if (kind >= 90 && kind < 95) begin
      msg = {msg, ebc_pkg::EscChar};
    end else if (kind >= 95) begin
      msg = {msg, ebc_pkg::EscChar};
      msg = {msg, escape_char()};
    end
    send_message(msg);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [31:0] val);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Wait for every result, then let the two-stage pipeline empty out.
  task automatic wait_drained();
    s_tvalid = 1'b0;
    while (pending != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic run_random_chars();
    int unsigned stop_at;
    stop_at = chars_sent + CharsPerPhase;
    while (chars_sent < stop_at) begin
      send_random_message();
    end
    wait_drained();
  endtask

  initial begin
    rst = 1'b1;
    s_tvalid = 1'b0;
    s_tdata = '0;
    s_tlast = 1'b0;
    cfg_valid = 1'b0;
    cfg_index = ebc_pkg::RegPolynomial;
    cfg_data = '0;
    hold_req = 1'b0;
    chars_sent = 0;
    src_idle_pct = 10;
    snk_idle_pct = 88;
    repeat (7) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;
    @(negedge clk);

    // Directed messages under the reset settings: byte extremes, a lone
    // percent, a message cut after the first escape character, percent
    // used as an escape character, and mixed escapes.
    send_message('{8'h00});
    send_message('{8'hFF});
    send_message('{ebc_pkg::EscChar});
    send_message('{ebc_pkg::EscChar, 8'h41});
    send_message('{ebc_pkg::EscChar, ebc_pkg::EscChar, ebc_pkg::EscChar});
    send_message('{8'h7F, ebc_pkg::EscChar, 8'hF0, 8'h0F, 8'h80});
    send_message('{ebc_pkg::EscChar, 8'hFF, 8'hFF, 8'h00, 8'hFF});
    send_message('{8'h31, 8'h32, 8'h33});
    wait_drained();

    // Receiver holds off while short messages keep coming, so the result
    // register fills and the input side stalls.
    src_idle_pct = 0;
    hold_req = 1'b1;
    repeat (30) begin
      send_random_message();
    end
    wait_drained();
    src_idle_pct = 10;

    run_random_chars();

    write_reg(ebc_pkg::RegPolynomial, 32'hFFFF_FFFF);
    write_reg(ebc_pkg::RegInitValue, 32'hFFFF_FFFF);
    write_reg(ebc_pkg::RegXorOut, 32'hFFFF_FFFF);
    write_reg(RegUnused, 32'($urandom));
    run_random_chars();

    src_idle_pct = 88;
    snk_idle_pct = 10;
    write_reg(ebc_pkg::RegPolynomial, 32'h0000_0000);
    write_reg(ebc_pkg::RegInitValue, 32'h0000_0000);
    write_reg(ebc_pkg::RegXorOut, 32'h0000_0000);
    run_random_chars();

    write_reg(ebc_pkg::RegPolynomial, 32'($urandom));
    write_reg(ebc_pkg::RegInitValue, 32'($urandom));
    write_reg(ebc_pkg::RegXorOut, 32'($urandom));
    run_random_chars();

    src_idle_pct = 0;
    snk_idle_pct = 0;
    write_reg(ebc_pkg::RegPolynomial, ebc_pkg::PolyReset);
    write_reg(ebc_pkg::RegInitValue, 32'hFFFF_FFFF);
    write_reg(ebc_pkg::RegXorOut, 32'hFFFF_FFFF);
    run_random_chars();

    write_reg(ebc_pkg::RegPolynomial, 32'($urandom));
    write_reg(ebc_pkg::RegInitValue, 32'($urandom));
    write_reg(ebc_pkg::RegXorOut, 32'($urandom));
    write_reg(RegUnused, 32'($urandom));
    run_random_chars();

    repeat (8) @(negedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
